[hw/rtl/hosting_name_keyword_matcher_assert.svh]
// Assertion macros shared by the keyword matcher RTL.
// Each macro takes a label, the clock, the reset, an antecedent, a consequent
// and a message string. In synthesis builds the macros expand to nothing.
`ifndef HOSTING_NAME_KEYWORD_MATCHER_ASSERT_SVH
`define HOSTING_NAME_KEYWORD_MATCHER_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the cycle after the antecedent.
`define HNKM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define HNKM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`else

`define HNKM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`define HNKM_ASSERT_SAME(label, clk, rst, ante, cons, msg)

`endif

`endif

[hw/rtl/hnkm_pkg.sv]
package hnkm_pkg;

   // Number of earlier bytes held in the window.
   localparam int WINDOW_DEPTH = 11;
   // Longest keyword: the window plus the current byte.
   localparam int KW_MAX = WINDOW_DEPTH + 1;
   localparam int KW_COUNT = 32;

   typedef logic [7:0] char_type;
   typedef logic [WINDOW_DEPTH-1:0][7:0] window_type;
   // Element 0 is the last character of a keyword, element k the one k places
   // earlier. Unused leading elements are zero and match anything.
   typedef logic [KW_MAX-1:0][7:0] kw_text_type;
   typedef logic [2:0] kw_class_type;

   localparam kw_class_type CLS_PLAIN      = 3'd0;
   localparam kw_class_type CLS_CLOUD      = 3'd1;
   localparam kw_class_type CLS_THE_CLOUD  = 3'd2;
   localparam kw_class_type CLS_HOST       = 3'd3;
   localparam kw_class_type CLS_GUARD_HOST = 3'd4;

   // Sticky seen flags, one per keyword class.
   typedef struct packed {
      logic plain;
      logic cloud;
      logic the_cloud;
      logic host;
      logic guard_host;
   } kw_hits_type;

   // Keyword text as ASCII, right aligned, so the hex reads left to right.
   localparam kw_text_type KW_TEXT [KW_COUNT] = '{
      96'h63646e,
      96'h636f6c6f636174696f6e,
      96'h636c6f7564,
      96'h74686520636c6f7564,
      96'h6461746163656e746572,
      96'h646174612063656e746572,
      96'h646174612d63656e746572,
      96'h64646f73,
      96'h64656469,
      96'h686f7374,
      96'h61667269686f7374,
      96'h6c61796572,
      96'h736572766572,
      96'h767073,
      96'h6865747a6e6572,
      96'h6f7668,
      96'h636f6e7461626f,
      96'h6469676974616c6f6365616e,
      96'h616d617a6f6e,
      96'h676f6f676c65206c6c63,
      96'h676f6f676c652c206c6c63,
      96'h616b616d6169,
      96'h6d6963726f736f6674,
      96'h616c6962616261,
      96'h666173746c79,
      96'h6c696e6f6465,
      96'h6172756261,
      96'h676f6461646479,
      96'h6f7261636c65,
      96'h6d323437,
      96'h6c65617365776562,
      96'h6970786f
   };

   localparam kw_class_type KW_CLASS [KW_COUNT] = '{
      CLS_PLAIN, CLS_PLAIN, CLS_CLOUD, CLS_THE_CLOUD,
      CLS_PLAIN, CLS_PLAIN, CLS_PLAIN, CLS_PLAIN,
      CLS_PLAIN, CLS_HOST, CLS_GUARD_HOST, CLS_PLAIN,
      CLS_PLAIN, CLS_PLAIN, CLS_PLAIN, CLS_PLAIN,
      CLS_PLAIN, CLS_PLAIN, CLS_PLAIN, CLS_PLAIN,
      CLS_PLAIN, CLS_PLAIN, CLS_PLAIN, CLS_PLAIN,
      CLS_PLAIN, CLS_PLAIN, CLS_PLAIN, CLS_PLAIN,
      CLS_PLAIN, CLS_PLAIN, CLS_PLAIN, CLS_PLAIN
   };

endpackage

[hw/rtl/hnkm_match.sv]
module hnkm_match (
   input  hnkm_pkg::window_type  window,
   input  hnkm_pkg::char_type    cur_char,
   output hnkm_pkg::kw_hits_type hits
);
   import hnkm_pkg::*;

   kw_text_type full;

   assign full = {window, cur_char};

   // Every keyword is compared against the window in parallel.
   always_comb begin
      logic kw_hit;
      hits = '0;
      kw_hit = 1'b0;
      for (int i = 0; i < KW_COUNT; i++) begin
         kw_hit = 1'b1;
         for (int k = 0; k < KW_MAX; k++) begin
            if (KW_TEXT[i][k] != 8'h00 && KW_TEXT[i][k] != full[k]) begin
               kw_hit = 1'b0;
            end
         end
         if (kw_hit) begin
            case (KW_CLASS[i])
               CLS_CLOUD:      hits.cloud = 1'b1;
               CLS_THE_CLOUD:  hits.the_cloud = 1'b1;
               CLS_HOST:       hits.host = 1'b1;
               CLS_GUARD_HOST: hits.guard_host = 1'b1;
               default:        hits.plain = 1'b1;
            endcase
         end
      end
   end

endmodule

[hw/rtl/hnkm_track.sv]
module hnkm_track (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  hnkm_pkg::char_type    cur_char,
   output hnkm_pkg::kw_hits_type seen
);
   import hnkm_pkg::*;

   window_type  window_ff;
   window_type  window_in;
   kw_hits_type seen_ff;
   kw_hits_type seen_in;
   kw_hits_type hits;

   hnkm_match u_match (
      .window   (window_ff),
      .cur_char (cur_char),
      .hits     (hits)
   );

   // A zero byte ends the string and clears the window and the flags.
   always_comb begin
      window_in = window_ff;
      seen_in   = seen_ff;
      if (step) begin
         if (cur_char == 8'h00) begin
            window_in = '0;
            seen_in   = '0;
         end else begin
            window_in = {window_ff[WINDOW_DEPTH-2:0], cur_char};
            seen_in   = seen_ff | hits;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         seen_ff   <= '0;
      end else begin
         window_ff <= window_in;
         seen_ff   <= seen_in;
      end
   end

   assign seen = seen_ff;

endmodule

[hw/rtl/hosting_name_keyword_matcher.sv]
// Keyword matcher for hosting-provider names. Each input word is one byte of
// a name string, and a zero byte ends the string. The block compares the
// current byte and the eleven bytes before it against a fixed, case-sensitive
// keyword list in combinational logic, keeps sticky flags for what it has
// seen, and on the zero byte returns one result word: is_hosting is 1 when a
// plain keyword was seen, or "cloud" without "the cloud", or "host" without
// the one guarded regional host name. Non-zero bytes return nothing. One byte
// is taken every cycle unless a zero byte meets a stalled result. The zero
// byte passes the input register, and the result register then holds the
// result word until it is taken. The input register can take a new byte
// while a finished result waits on the output; only a second zero byte
// meeting a stalled result holds the input.
`include "hosting_name_keyword_matcher_assert.svh"

module hosting_name_keyword_matcher (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_is_hosting
);
   import hnkm_pkg::*;

   // Input register.
   logic        in_valid_ff;
   logic        in_valid_in;
   char_type    in_byte_ff;
   char_type    in_byte_in;

   // Result register.
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic        rsp_hit_ff;
   logic        rsp_hit_in;

   logic        zero_byte;
   logic        out_free;
   logic        in_fire;
   logic        zero_fire;
   logic        req_take;
   logic        hit;
   kw_hits_type seen;

   // A non-zero byte never needs the result register, so it always moves on.
   // A zero byte moves on only when the result register is free this cycle.
   assign zero_byte = (in_byte_ff == 8'h00);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign in_fire   = in_valid_ff && (!zero_byte || out_free);
   assign zero_fire = in_fire && zero_byte;
   assign req_stall = in_valid_ff && !in_fire;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in = req_take || (in_valid_ff && !in_fire);
   assign in_byte_in  = req_take ? req_text_byte : in_byte_ff;

   hnkm_track u_track (
      .clock    (clock),
      .reset    (reset),
      .step     (in_fire),
      .cur_char (in_byte_ff),
      .seen     (seen)
   );

   // The zero byte itself matches no keyword, so the flags as they stand are
   // the complete record of the string.
   assign hit = seen.plain || (seen.cloud && !seen.the_cloud) ||
                (seen.host && !seen.guard_host);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      if (zero_fire) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      rsp_hit_ff <= rsp_hit_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_hosting = rsp_hit_ff;

   `HNKM_ASSERT_NEXT(a_end_gives_result, clock, reset, zero_fire, rsp_valid_ff, "end of string without result")
   `HNKM_ASSERT_NEXT(a_end_clears_flags, clock, reset, zero_fire, seen == '0, "flags not cleared at end of string")
   `HNKM_ASSERT_SAME(a_result_from_end, clock, reset, $rose(rsp_valid_ff), $past(zero_fire), "result without end of string")
   `HNKM_ASSERT_SAME(a_no_overwrite, clock, reset, rsp_valid_ff && rsp_stall, !zero_fire, "stalled result overwritten")
   `HNKM_ASSERT_NEXT(a_result_drains, clock, reset, rsp_valid_ff && !rsp_stall && !zero_fire, !rsp_valid_ff, "taken result repeated")

endmodule

[verif/tb_top.sv]
module tb_top;
   import hnkm_pkg::*;

   // Run shape. Each of the four idling phases sends about this many bytes.
   localparam int ITEMS_PER_PHASE = 350;
   // The long receiver hold-off, in cycles. It must stay well below the limit.
   localparam int HOLD_CYCLES = 300;
   // Cycles with no accepted word on either channel before the run gives up.
   localparam int QUIET_LIMIT = 3000;
   // Settle after the last result, before the run prints its verdict.
   localparam int SETTLE_CYCLES = 8;

   // The keyword list, written out here on its own so that a slip in the
   // block's copy shows up as a mismatch. Each entry is ASCII, right
   // aligned: byte 0 is the last character and zero bytes pad the front.
   localparam int KEYWORD_TOTAL = 32;
   localparam kw_text_type KEYWORD_TEXT [KEYWORD_TOTAL] = '{
      96'h63646e,
      96'h636f6c6f636174696f6e,
      96'h636c6f7564,
      96'h74686520636c6f7564,
      96'h6461746163656e746572,
      96'h646174612063656e746572,
      96'h646174612d63656e746572,
      96'h64646f73,
      96'h64656469,
      96'h686f7374,
      96'h61667269686f7374,
      96'h6c61796572,
      96'h736572766572,
      96'h767073,
      96'h6865747a6e6572,
      96'h6f7668,
      96'h636f6e7461626f,
      96'h6469676974616c6f6365616e,
      96'h616d617a6f6e,
      96'h676f6f676c65206c6c63,
      96'h676f6f676c652c206c6c63,
      96'h616b616d6169,
      96'h6d6963726f736f6674,
      96'h616c6962616261,
      96'h666173746c79,
      96'h6c696e6f6465,
      96'h6172756261,
      96'h676f6461646479,
      96'h6f7261636c65,
      96'h6d323437,
      96'h6c65617365776562,
      96'h6970786f
   };

   // Only cloud, the cloud, host and the guarded host name are guarded;
   // everything else is plain.
   localparam kw_class_type KEYWORD_KIND [KEYWORD_TOTAL] = '{
      CLS_PLAIN, CLS_PLAIN, CLS_CLOUD, CLS_THE_CLOUD,
      CLS_PLAIN, CLS_PLAIN, CLS_PLAIN, CLS_PLAIN,
      CLS_PLAIN, CLS_HOST, CLS_GUARD_HOST, CLS_PLAIN,
      CLS_PLAIN, CLS_PLAIN, CLS_PLAIN, CLS_PLAIN,
      CLS_PLAIN, CLS_PLAIN, CLS_PLAIN, CLS_PLAIN,
      CLS_PLAIN, CLS_PLAIN, CLS_PLAIN, CLS_PLAIN,
      CLS_PLAIN, CLS_PLAIN, CLS_PLAIN, CLS_PLAIN,
      CLS_PLAIN, CLS_PLAIN, CLS_PLAIN, CLS_PLAIN
   };

   // Indexes of the four guarded keywords, used to stress the two exceptions.
   localparam int GUARDED_KEYWORDS [4] = '{2, 3, 9, 10};

   // Building blocks of a random name string.
   typedef enum {
      PIECE_KEYWORD,
      PIECE_GUARDED,
      PIECE_MANGLED,
      PIECE_PREFIX,
      PIECE_LETTERS,
      PIECE_RAW
   } piece_kind_type;

   // The scoreboard keeps its own window and sticky flags, works out the
   // verdict when a zero byte is accepted, and checks each result word
   // against the oldest verdict still owed.
   class hosting_verdict_board;
      window_type recent;
      kw_hits_type seen;
      bit verdicts_due [$];
      int mismatches;

      function new();
         recent = '0;
         seen = '0;
         mismatches = 0;
      endfunction

      task report(string what);
         $display("[tb] %0t mismatch: %s", $time, what);
         mismatches++;
      endtask

      function void note_byte(char_type b);
         kw_text_type word;
         bit hit;
         if (b == 8'h00) begin
            verdicts_due.push_back(seen.plain || (seen.cloud && !seen.the_cloud)
                                   || (seen.host && !seen.guard_host));
            recent = '0;
            seen = '0;
            return;
         end
         for (int i = 0; i < KEYWORD_TOTAL; i++) begin
            word = KEYWORD_TEXT[i];
            hit = (word[0] == b);
            // Padding bytes are zero and never constrain the window.
            for (int k = 1; k < KW_MAX; k++) begin
               if (word[k] != 8'h00 && word[k] != recent[k-1]) hit = 1'b0;
            end
            if (hit) begin
               case (KEYWORD_KIND[i])
                  CLS_CLOUD:      seen.cloud = 1'b1;
                  CLS_THE_CLOUD:  seen.the_cloud = 1'b1;
                  CLS_HOST:       seen.host = 1'b1;
                  CLS_GUARD_HOST: seen.guard_host = 1'b1;
                  default:        seen.plain = 1'b1;
               endcase
            end
         end
         recent = {recent[WINDOW_DEPTH-2:0], b};
      endfunction

      task check_verdict(logic got);
         bit want;
         if (verdicts_due.size() == 0) begin
            report($sformatf("is_hosting=%0b arrived with no string ended", got));
            return;
         end
         want = verdicts_due.pop_front();
         if (got !== want) begin
            report($sformatf("is_hosting=%0b, expected %0b", got, want));
         end
      endtask

      function int pending();
         return verdicts_due.size();
      endfunction
   endclass

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_text_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_is_hosting;

   hosting_verdict_board board = new();

   // Idling odds in percent per cycle, set by the stimulus per phase.
   int send_idle_pct = 0;
   int stall_pct = 0;
   // Raised by the stimulus to ask the receiver for one long hold-off.
   bit hold_wanted = 1'b0;
   int phase_items;
   int quiet_cycles = 0;
   // The name string under construction, zero byte included.
   char_type name_bytes [$];

   hosting_name_keyword_matcher i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_text_byte  (req_text_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_is_hosting (rsp_is_hosting)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Both channels are sampled here at the edge, before any nonblocking
   // update of that edge lands, so the values seen are the ones the block
   // saw. A result never shares an edge with its zero byte, which passes the
   // input and result registers first, so the check order does not matter.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) board.check_verdict(rsp_is_hosting);
         if (req_valid && !req_stall) board.note_byte(req_text_byte);
      end
   end

   // Watchdog: any accepted word on either side restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[hosting_name_keyword_matcher] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver. Normally it stalls at random with the phase odds. When a long
   // hold-off is asked for, it keeps the stall up and counts the cycles
   // itself while the sender keeps offering bytes.
   initial begin : receiver
      int held;
      forever begin
         @(posedge clock);
         if (hold_wanted) begin
            rsp_stall <= 1'b1;
            for (held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
            hold_wanted = 1'b0;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Offers one byte and returns at the edge that accepts it. An idle gap,
   // if one is drawn, comes first; valid then drops at the edge that took
   // the previous word and rises again at a later edge.
   task automatic send_byte(input char_type b);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_text_byte <= char_type'($urandom);
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_text_byte <= b;
      do @(posedge clock); while (req_stall);
      phase_items++;
   endtask

   task automatic send_name();
      while (name_bytes.size() != 0) send_byte(name_bytes.pop_front());
   endtask

   // Lowers valid and waits until every owed verdict has come back. The wait
   // always spans an edge, so valid never drops and rises in the same step.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) name_bytes.push_back(s[i]);
   endfunction

   function automatic void add_keyword(int idx);
      kw_text_type word;
      int len;
      word = KEYWORD_TEXT[idx];
      len = 0;
      while (len < KW_MAX && word[len] != 8'h00) len++;
      for (int j = len - 1; j >= 0; j--) name_bytes.push_back(word[j]);
   endfunction

   // Most strings are made of keywords, near misses and filler, so that the
   // window really matches and the guarded pairs meet each other. A few are
   // pure noise, and a few are long to show that the flags stay sticky.
   function automatic void build_name();
      int r;
      int pieces;
      int n;
      int start;
      int pos;
      piece_kind_type kind;
      r = $urandom_range(99);
      if (r < 8) begin
         n = $urandom_range(1, 12);
         repeat (n) name_bytes.push_back(char_type'($urandom_range(1, 255)));
      end else begin
         pieces = (r < 14) ? $urandom_range(10, 20) : $urandom_range(0, 4);
         repeat (pieces) begin
            r = $urandom_range(9);
            kind = (r < 3) ? PIECE_KEYWORD : (r < 5) ? PIECE_GUARDED :
                   (r == 5) ? PIECE_MANGLED : (r == 6) ? PIECE_PREFIX :
                   (r < 9) ? PIECE_LETTERS : PIECE_RAW;
            case (kind)
               PIECE_KEYWORD: add_keyword($urandom_range(KEYWORD_TOTAL - 1));
               PIECE_GUARDED: add_keyword(GUARDED_KEYWORDS[$urandom_range(3)]);
               PIECE_MANGLED: begin
                  // Flip the case of one character; a space would turn into a
                  // terminator, so it becomes DEL instead.
                  start = name_bytes.size();
                  add_keyword($urandom_range(KEYWORD_TOTAL - 1));
                  pos = $urandom_range(start, name_bytes.size() - 1);
                  name_bytes[pos] ^= 8'h20;
                  if (name_bytes[pos] == 8'h00) name_bytes[pos] = 8'h7f;
               end
               PIECE_PREFIX: begin
                  start = name_bytes.size();
                  add_keyword($urandom_range(KEYWORD_TOTAL - 1));
                  n = $urandom_range(1, name_bytes.size() - start - 1);
                  repeat (n) void'(name_bytes.pop_back());
               end
               PIECE_LETTERS: begin
                  n = $urandom_range(1, 4);
                  repeat (n) begin
                     name_bytes.push_back(($urandom_range(3) == 0) ? 8'h20 :
                                          char_type'(8'h61 + $urandom_range(25)));
                  end
               end
               default: name_bytes.push_back(char_type'($urandom_range(1, 255)));
            endcase
         end
      end
      name_bytes.push_back(8'h00);
   endfunction

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Phases: no idling, sender mostly idle, receiver mostly stalling,
      // then light idling on both sides.
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1) ? 80 : (phase == 3) ? 14 : 0;
         stall_pct = (phase == 2) ? 80 : (phase == 3) ? 14 : 0;
         phase_items = 0;
         if (phase == 0) begin
            // Empty string, the extreme byte values, a keyword split by a
            // terminator (the cleared window must not join the halves), a
            // lone guarded keyword, a plain keyword, and the same keyword
            // with a capital letter, which must not match.
            name_bytes = {8'h00, 8'hff, 8'h01, 8'h00};
            add_text("clo");
            name_bytes.push_back(8'h00);
            add_text("ud");
            name_bytes.push_back(8'h00);
            add_text("host");
            name_bytes.push_back(8'h00);
            add_text("cdn");
            name_bytes.push_back(8'h00);
            add_text("Cdn");
            name_bytes.push_back(8'h00);
            send_name();
            drain();

            // Long hold-off on the result side while strings keep coming:
            // one result waits, the next zero byte fills the block, and the
            // input has to stall until the receiver lets go.
            hold_wanted = 1'b1;
            repeat (6) begin
               build_name();
               send_name();
            end
         end
         while (phase_items < ITEMS_PER_PHASE) begin
            build_name();
            send_name();
         end
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("[hosting_name_keyword_matcher] OK");
      end else begin
         $display("[hosting_name_keyword_matcher] ERROR");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/hnkm_pkg.sv
hw/rtl/hnkm_match.sv
hw/rtl/hnkm_track.sv
hw/rtl/hosting_name_keyword_matcher.sv
verif/tb_top.sv
